FILE: sv/sahc_pkg.sv
// shared types and constants for the sample address hash counter
// no dependencies; imported by the hash unit and the top level
package sahc_pkg;

    localparam int ADDR_W   = 64;
    localparam int COUNT_W  = 32;
    localparam int SEL_W    = 12;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 64;
    localparam int HASH_W   = 16;
    localparam int WORD_W   = ADDR_W + COUNT_W;

    localparam logic [63:0] GOLDEN_MUL = 64'h9E37_79B9_7F4A_7C15;
    localparam int          HASH_SHIFT = 48;
    localparam int          ADDR_SHIFT = 2;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_COUNTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ     = 3'd4;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] sample_address;
        logic [SEL_W-1:0]  slot_select;
    } sahc_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SEL_W-1:0]    slot_used;
        logic [ADDR_W-1:0]   slot_address;
        logic [COUNT_W-1:0]  slot_count;
        logic [TOTAL_W-1:0]  total_samples;
        logic [TOTAL_W-1:0]  dropped_samples;
    } sahc_rsp_t;

endpackage

FILE: sv/sahc_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module sahc_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/sahc_hash.sv
// golden-ratio hash of a sample address, low 64 product bits built from
// three 32x32 partial products on one shared multiplier; uses sahc_pkg
module sahc_hash
    import sahc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ADDR_W-1:0] addr,
    output logic              done,
    output logic [HASH_W-1:0] hash
);

    logic [63:0] a_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;

    // step 0: lo*lo, step 1: lo*hi, step 2: hi*lo
    assign mul_a = (step_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
    assign mul_b = (step_reg == 2'd1) ? GOLDEN_MUL[63:32] : GOLDEN_MUL[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 2'd3);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= addr >> ADDR_SHIFT;
        end
        if (busy_reg)
        begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
            if (step_reg == 2'd1)
            begin
                acc_reg <= prod_reg;
            end
            else if (step_reg[1])
            begin
                // cross terms only reach the upper half
                acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            end
        end
    end

    assign done = done_reg;
    assign hash = acc_reg[HASH_SHIFT +: HASH_W];

endmodule

FILE: sv/sample_address_hash_counter_core.sv
// top level of the sample address hash counter: control sequencer, counters
// and result register; uses sahc_pkg, sahc_hash and sahc_ram
//
//  channel | direction | handshake             | word
//  req     | in        | req_valid / req_ready | sahc_req_t
//  rsp     | out       | rsp_valid / rsp_ready | sahc_rsp_t
//
// one word at a time; a record is set by the hash (four multiply steps and a
// done strobe) and one table probe per cycle, up to MAX_PROBES probes
// a read runs the slot reduction, then the S_RD_ADDR, S_RD_DATA and S_DONE states
// after reset the table is swept clear, every slot once, with req_ready low
// a stalled rsp holds the next result in the sequencer; req is taken while
// a result waits on rsp
module sample_address_hash_counter_core
    import sahc_pkg::*;
#(
    parameter int SLOTS      = 4096,
    parameter int MAX_PROBES = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  sahc_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output sahc_rsp_t rsp
);

    localparam int IDX_W     = $clog2(SLOTS);
    localparam int PW        = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
    localparam int SUM_W     = HASH_W + 1;
    localparam int RED_STEPS = (SLOTS >= 4096) ? 1 : (13 - $clog2(SLOTS));
    localparam logic [IDX_W-1:0] IDX_MASK   = IDX_W'(SLOTS - 1);
    localparam logic [PW-1:0]    PROBE_LAST = PW'(MAX_PROBES - 1);
    localparam logic [3:0]       RED_FIRST  = 4'(RED_STEPS - 1);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_HASH    = 3'd2;
    localparam logic [2:0] S_PROBE   = 3'd3;
    localparam logic [2:0] S_REDUCE  = 3'd4;
    localparam logic [2:0] S_RD_ADDR = 3'd5;
    localparam logic [2:0] S_RD_DATA = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [PW-1:0]       p_reg, p_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [ADDR_W-1:0]   sample_reg, sample_next;
    logic [SEL_W-1:0]    sel_reg, sel_next;
    logic [3:0]          red_k_reg, red_k_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [TOTAL_W-1:0]  drop_reg, drop_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SEL_W-1:0]    res_slot_reg, res_slot_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [COUNT_W-1:0]  res_count_reg, res_count_next;
    sahc_rsp_t           rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [IDX_W-1:0]    rd_idx_reg;

    logic                hash_start;
    logic                hash_done;
    logic [HASH_W-1:0]   hash_value;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;
    logic [ADDR_W-1:0]   cur_addr;
    logic [COUNT_W-1:0]  cur_count;

    logic [HASH_W-1:0]   probe_base;
    logic [SUM_W-1:0]    probe_off;
    logic [SUM_W-1:0]    probe_sum;
    logic [IDX_W-1:0]    probe_idx;
    logic [31:0]         used_wide;
    logic [31:0]         sel_wide;
    logic [31:0]         red_sub;

    sahc_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .addr  (req.sample_address),
        .done  (hash_done),
        .hash  (hash_value)
    );

    sahc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_addr  = ram_rdata[WORD_W-1:COUNT_W];
    assign cur_count = ram_rdata[COUNT_W-1:0];

    // first probe leaves straight from the hash unit, later ones look one ahead
    assign probe_base = (state_reg == S_HASH) ? hash_value : hash_reg;
    assign probe_off  = (state_reg == S_HASH) ? '0 : SUM_W'(p_reg) + SUM_W'(1);
    assign probe_sum  = SUM_W'(probe_base) + probe_off;
    assign probe_idx  = probe_sum[IDX_W-1:0] & IDX_MASK;

    assign used_wide = 32'(rd_idx_reg);
    assign sel_wide  = 32'(sel_reg);
    assign red_sub   = 32'(SLOTS) << red_k_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        p_next          = p_reg;
        hash_next       = hash_reg;
        sample_next     = sample_reg;
        sel_next        = sel_reg;
        red_k_next      = red_k_reg;
        total_next      = total_reg;
        drop_next       = drop_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_addr_next   = res_addr_reg;
        res_count_next  = res_count_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        hash_start      = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = rd_idx_reg;
        ram_wdata       = '0;
        ram_raddr       = rd_idx_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.operation == OP_READ)
                    begin
                        sel_next   = req.slot_select;
                        red_k_next = RED_FIRST;
                        state_next = S_REDUCE;
                    end
                    else if (req.sample_address == '0)
                    begin
                        res_status_next = ST_IGNORED;
                        res_slot_next   = '0;
                        res_addr_next   = '0;
                        res_count_next  = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        sample_next = req.sample_address;
                        total_next  = total_reg + TOTAL_W'(1);
                        hash_start  = 1'b1;
                        state_next  = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                ram_raddr = probe_idx;
                if (hash_done)
                begin
                    hash_next  = hash_value;
                    p_next     = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                ram_raddr = probe_idx;
                if (cur_addr == sample_reg)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = {sample_reg, cur_count + COUNT_W'(1)};
                    res_status_next = ST_COUNTED;
                    res_slot_next   = used_wide[SEL_W-1:0];
                    res_addr_next   = sample_reg;
                    res_count_next  = cur_count + COUNT_W'(1);
                    state_next      = S_DONE;
                end
                else if (cur_addr == '0)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = {sample_reg, COUNT_W'(1)};
                    res_status_next = ST_INSERTED;
                    res_slot_next   = used_wide[SEL_W-1:0];
                    res_addr_next   = sample_reg;
                    res_count_next  = COUNT_W'(1);
                    state_next      = S_DONE;
                end
                else if (p_reg == PROBE_LAST)
                begin
                    drop_next       = drop_reg + TOTAL_W'(1);
                    res_status_next = ST_DROPPED;
                    res_slot_next   = '0;
                    res_addr_next   = '0;
                    res_count_next  = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    p_next = p_reg + PW'(1);
                end
            end
            S_REDUCE:
            begin
                // restoring subtract of SLOTS << k brings the select into range
                if (sel_wide >= red_sub)
                begin
                    sel_next = sel_reg - red_sub[SEL_W-1:0];
                end
                if (red_k_reg == 4'd0)
                begin
                    state_next = S_RD_ADDR;
                end
                else
                begin
                    red_k_next = red_k_reg - 4'd1;
                end
            end
            S_RD_ADDR:
            begin
                ram_raddr  = sel_wide[IDX_W-1:0];
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                // keep the owner address, zero the count
                ram_we          = 1'b1;
                ram_wdata       = {cur_addr, COUNT_W'(0)};
                res_status_next = ST_READ;
                res_slot_next   = used_wide[SEL_W-1:0];
                res_addr_next   = cur_addr;
                res_count_next  = cur_count;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status          = res_status_reg;
                    rsp_next.slot_used       = res_slot_reg;
                    rsp_next.slot_address    = res_addr_reg;
                    rsp_next.slot_count      = res_count_reg;
                    rsp_next.total_samples   = total_reg;
                    rsp_next.dropped_samples = drop_reg;
                    rsp_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            p_reg         <= '0;
            red_k_reg     <= '0;
            total_reg     <= '0;
            drop_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            p_reg         <= p_next;
            red_k_reg     <= red_k_next;
            total_reg     <= total_next;
            drop_reg      <= drop_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg       <= hash_next;
        sample_reg     <= sample_next;
        sel_reg        <= sel_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_addr_reg   <= res_addr_next;
        res_count_reg  <= res_count_next;
        rsp_reg        <= rsp_next;
        rd_idx_reg     <= ram_raddr;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
